[src/trap_integer_and_double_helper_macros.svh]
// Assertion macros used by the trap helper RTL
`ifndef TRAP_INTEGER_AND_DOUBLE_HELPER_MACROS_SVH
`define TRAP_INTEGER_AND_DOUBLE_HELPER_MACROS_SVH
// implication checked every clock, quiet in reset
`define TIDH_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define TIDH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

[src/tidh_pkg.sv]
`default_nettype none
package tidh_pkg;
   localparam int WORD_BITS = 32;
   localparam int DIV_STAGES = WORD_BITS;

   typedef enum logic [2:0] {
      OP_MUL = 3'd0, OP_DIV = 3'd1, OP_MOD = 3'd2, OP_DIVMOD = 3'd3,
      OP_MODREG = 3'd4, OP_DTEST = 3'd5, OP_D2I = 3'd6, OP_U2D = 3'd7
   } op_type;

   typedef struct packed {
      logic [31:0] first_result;
      logic [31:0] second_result;
      logic first_written;
      logic second_written;
      logic carry_request;
      logic zero_flag;
      logic negative_flag;
      logic flags_written;
   } result_type;
endpackage
`default_nettype wire

[src/tidh_div_pipe.sv]
`default_nettype none
// Restoring divider, one quotient bit per stage.
module tidh_div_pipe
   import tidh_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [WORD_BITS-1:0] in_dividend,
   input  wire logic [WORD_BITS-1:0] in_divisor,
   input  wire result_type           in_side,
   output logic                      out_valid,
   output logic [WORD_BITS-1:0]      out_quotient,
   output logic [WORD_BITS-1:0]      out_remainder,
   output result_type                out_side
);
   logic                 vld_ff  [DIV_STAGES+1];
   logic [WORD_BITS-1:0] quo_ff  [DIV_STAGES+1];
   logic [WORD_BITS-1:0] rem_ff  [DIV_STAGES+1];
   logic [WORD_BITS-1:0] dvs_ff  [DIV_STAGES+1];
   result_type           side_ff [DIV_STAGES+1];

   always_comb begin
      vld_ff[0]  = in_valid;
      quo_ff[0]  = in_dividend;
      rem_ff[0]  = '0;
      dvs_ff[0]  = in_divisor;
      side_ff[0] = in_side;
   end

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic [WORD_BITS:0]   trial;
      logic [WORD_BITS-1:0] rem_in, quo_in;
      always_comb begin
         trial = {rem_ff[s], quo_ff[s][WORD_BITS-1]} - {1'b0, dvs_ff[s]};
         if (!trial[WORD_BITS]) begin
            rem_in = trial[WORD_BITS-1:0];
            quo_in = {quo_ff[s][WORD_BITS-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[s][WORD_BITS-2:0], quo_ff[s][WORD_BITS-1]};
            quo_in = {quo_ff[s][WORD_BITS-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) vld_ff[s+1] <= 1'b0;
         else       vld_ff[s+1] <= vld_ff[s];
         rem_ff[s+1]  <= rem_in;
         quo_ff[s+1]  <= quo_in;
         dvs_ff[s+1]  <= dvs_ff[s];
         side_ff[s+1] <= side_ff[s];
      end
   end

   assign out_valid     = vld_ff[DIV_STAGES];
   assign out_quotient  = quo_ff[DIV_STAGES];
   assign out_remainder = rem_ff[DIV_STAGES];
   assign out_side      = side_ff[DIV_STAGES];
endmodule
`default_nettype wire

[src/trap_integer_and_double_helper.sv]
`default_nettype none
// Trap arithmetic helper.
// Input: raise start with req_operation, req_first_word, req_second_word;
// the transaction is taken on any edge with start high and busy low.
// busy is tied low: a transaction may be issued every cycle.
// Output: rsp_valid is high for one cycle per transaction, carrying every
// result field; the receiver cannot stall and need not.
// Pipeline: every operation takes the same path. A result is registered
// through one decode/multiply stage, 32 restoring divider stages and one
// output register before it sits on the rsp_ ports. Every op travels the
// same pipe, keeping order.
// Throughput: one transaction per cycle.
// Reset clears all valid bits; payload registers are not reset.
// Ops: mul, div, mod, divmod, mod_reg, double test, double-to-int32
// (saturating, NaN gives 0), uint32-to-double (exact).
module trap_integer_and_double_helper
   import tidh_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_operation,
   input  wire logic [31:0] req_first_word,
   input  wire logic [31:0] req_second_word,
   output logic             rsp_valid,
   output logic [31:0]      rsp_first_result,
   output logic [31:0]      rsp_second_result,
   output logic             rsp_first_written,
   output logic             rsp_second_written,
   output logic             rsp_carry_request,
   output logic             rsp_zero_flag,
   output logic             rsp_negative_flag,
   output logic             rsp_flags_written
);
`include "trap_integer_and_double_helper_macros.svh"

   assign busy = 1'b0;

   // ---- stage 1: decode, multiply, double ops ----
   op_type               op;
   logic [WORD_BITS-1:0] a, b;
   logic [63:0]          prod;
   logic [10:0]          ex;
   logic [51:0]          man;
   logic                 sg, is_nan, is_zero;
   logic [31:0]          d2i, mag;
   logic [84:0]          shv;
   logic [31:0]          u_hi, u_lo;
   logic [4:0]           lz;
   logic [31:0]          norm;
   result_type           side_in;

   always_comb begin
      op      = op_type'(req_operation);
      a       = req_first_word[WORD_BITS-1:0];
      b       = req_second_word[WORD_BITS-1:0];
      prod    = 64'(a) * 64'(b);
      sg      = req_first_word[31];
      ex      = req_first_word[30:20];
      man     = {req_first_word[19:0], req_second_word};
      is_nan  = (ex == 11'h7ff) && (man != '0);
      is_zero = (ex == '0) && (man == '0);
      // truncation: value = 1.man * 2^(ex-1023)
      shv = '0;
      mag = '0;
      if (ex >= 11'd1023 && ex <= 11'd1053) begin
         shv = {32'd1, man, 1'b0} << (ex - 11'd1023);
         mag = shv[84:53];
      end
      // |value| >= 2^31 saturates; every negative one lands on 0x80000000
      if (is_nan)
         d2i = '0;
      else if (ex > 11'd1053)
         d2i = sg ? 32'h8000_0000 : 32'h7fff_ffff;
      else
         d2i = sg ? 32'(-mag) : mag;
      // uint to double: leading-zero count by priority scan
      lz = '0;
      for (int i = 0; i < 32; i++)
         if (req_first_word[i]) lz = 5'(31 - i);
      norm = req_first_word << lz;
      if (req_first_word == '0) begin
         u_hi = '0;
         u_lo = '0;
      end else begin
         u_hi = {1'b0, 11'(11'd1054 - 11'(lz)), norm[30:11]};
         u_lo = {norm[10:0], 21'd0};
      end

      side_in = '0;
      unique case (op)
         OP_MUL: begin
            side_in.first_result  = 32'(prod[WORD_BITS-1:0]);
            side_in.first_written = 1'b1;
         end
         OP_DIV, OP_MOD: begin
            side_in.first_written = 1'b1;
            side_in.carry_request = (b == '0);
         end
         OP_DIVMOD: begin
            side_in.first_written  = (b != '0);
            side_in.second_written = (b != '0);
            side_in.carry_request  = (b == '0);
         end
         OP_MODREG: begin
            side_in.first_written = (b != '0);
            side_in.carry_request = (b == '0);
         end
         OP_DTEST: begin
            side_in.zero_flag     = is_zero;
            side_in.negative_flag = sg && !is_zero && !is_nan;
            side_in.flags_written = 1'b1;
         end
         OP_D2I: begin
            side_in.first_result  = d2i;
            side_in.first_written = 1'b1;
         end
         OP_U2D: begin
            side_in.first_result   = u_hi;
            side_in.second_result  = u_lo;
            side_in.first_written  = 1'b1;
            side_in.second_written = 1'b1;
         end
         default: side_in = '0;
      endcase
   end

   logic                 s1_vld_ff;
   logic [WORD_BITS-1:0] s1_a_ff, s1_b_ff;
   result_type           s1_side_ff;
   op_type               s1_op_ff;
   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else       s1_vld_ff <= start && !busy;
      s1_a_ff    <= a;
      s1_b_ff    <= b;
      s1_side_ff <= side_in;
      s1_op_ff   <= op;
   end

   // ---- divider stages ----
   logic                 dv_vld;
   logic [WORD_BITS-1:0] dv_q, dv_r;
   result_type           dv_side;
   logic [2:0]           dv_op_ff [DIV_STAGES+1];
   tidh_div_pipe u_div (
      .clock, .reset,
      .in_valid     (s1_vld_ff),
      .in_dividend  (s1_a_ff),
      .in_divisor   (s1_b_ff),
      .in_side      (s1_side_ff),
      .out_valid    (dv_vld),
      .out_quotient (dv_q),
      .out_remainder(dv_r),
      .out_side     (dv_side)
   );
   assign dv_op_ff[0] = s1_op_ff;
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_op
      always_ff @(posedge clock) dv_op_ff[k+1] <= dv_op_ff[k];
   end

   // ---- output merge ----
   result_type res_in;
   op_type     last_op;
   logic       dz;
   always_comb begin
      last_op = op_type'(dv_op_ff[DIV_STAGES]);
      dz      = dv_side.carry_request;
      res_in  = dv_side;
      case (last_op)
         OP_DIV:    res_in.first_result = dz ? '0 : 32'(dv_q);
         OP_MOD:    res_in.first_result = dz ? '0 : 32'(dv_r);
         OP_DIVMOD: begin
            res_in.first_result  = dz ? '0 : 32'(dv_q);
            res_in.second_result = dz ? '0 : 32'(dv_r);
         end
         OP_MODREG: res_in.first_result = dz ? '0 : 32'(dv_r);
         default:   res_in = dv_side;
      endcase
   end

   logic       out_vld_ff;
   result_type out_ff;
   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else       out_vld_ff <= dv_vld;
      out_ff <= res_in;
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_first_result   = out_ff.first_result;
   assign rsp_second_result  = out_ff.second_result;
   assign rsp_first_written  = out_ff.first_written;
   assign rsp_second_written = out_ff.second_written;
   assign rsp_carry_request  = out_ff.carry_request;
   assign rsp_zero_flag      = out_ff.zero_flag;
   assign rsp_negative_flag  = out_ff.negative_flag;
   assign rsp_flags_written  = out_ff.flags_written;

   `TIDH_ASSERT_IMPL(a_flags_alone, clock, reset,
      rsp_valid && rsp_flags_written,
      !rsp_first_written && !rsp_second_written && !rsp_carry_request,
      "flags written together with a result word")
   `TIDH_ASSERT_IMPL(a_carry_no_second, clock, reset,
      rsp_valid && rsp_carry_request, !rsp_second_written,
      "divide by zero wrote a remainder")
   `TIDH_ASSERT_NEXT(a_merge_valid, clock, reset,
      dv_vld, rsp_valid, "divider output lost at merge")
endmodule
`default_nettype wire
